FILE: hdl/rpn_pkg.sv
// Shared constants and types for the RPN stack calculator.
package rpn_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int OP_W        = 3;
	localparam int STATUS_W    = 3;
	localparam int DEPTH_OUT_W = 5;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int DIV_W       = DATA_W + FRAC_BITS;
	localparam int CNT_W       = $clog2(DIV_W + 1);
	localparam int ALU_W       = DATA_W + 2;
	localparam int PROD_W      = 2 * DATA_W;

	localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [PROD_W-1:0] POS_LIMIT = PROD_W'(MAX_VAL);
	localparam logic [PROD_W-1:0] NEG_LIMIT = PROD_W'(MIN_VAL);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_REM  = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 3'd0,
		ST_FEW  = 3'd1,
		ST_FULL = 3'd2,
		ST_DIV0 = 3'd3,
		ST_SAT  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_CALC,
		S_FIN
	} state_t;

endpackage

FILE: hdl/rpn_stack_calculator.sv
// RPN calculator: operand stack memory, one shared add/subtract unit, small sequencer.
// Push goes to the finishing state; other items load the top two entries, then
// calculate: add/subtract, multiply (32 shift-add steps) or divide/remainder (48
// restoring steps). Invalid code, too few operands or zero divisor skip to the finish.
// One item in flight; the next is taken once the result sits in the output register.
// Reset (arst_n low) empties the stack and drops any pending result.
module rpn_stack_calculator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [rpn_pkg::OP_W-1:0]            operation,
	input  logic signed [rpn_pkg::DATA_W-1:0]   push_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [rpn_pkg::DATA_W-1:0]   result_value,
	output logic [rpn_pkg::STATUS_W-1:0]        status,
	output logic [rpn_pkg::DEPTH_OUT_W-1:0]     stack_depth
);

	rpn_pkg::state_t state_q, state_d;

	logic [rpn_pkg::OP_W-1:0]   op_q;
	logic [rpn_pkg::DATA_W-1:0] push_q;
	logic [rpn_pkg::SP_W-1:0]   sp_q;
	logic [rpn_pkg::SP_W-1:0]   sp_m1, sp_m2;
	logic [rpn_pkg::IDX_W-1:0]  ra, rb;

	logic [rpn_pkg::DATA_W-1:0] mem [rpn_pkg::STACK_DEPTH];
	logic [rpn_pkg::DATA_W-1:0] rd_a_q, rd_b_q;

	logic [rpn_pkg::DATA_W-1:0] ma_q, mb_q;
	logic [rpn_pkg::DATA_W-1:0] ma_c, mb_c;
	logic [rpn_pkg::DATA_W:0]   acc_q;
	logic [rpn_pkg::DIV_W-1:0]  work_q;
	logic [rpn_pkg::DIV_W-1:0]  mul_work;
	logic [rpn_pkg::CNT_W-1:0]  cnt_q;

	logic [rpn_pkg::ALU_W-1:0]  alu_x, alu_y, alu_sum;
	logic                       alu_sub;

	logic                       out_valid_q;
	logic [rpn_pkg::DATA_W-1:0] res_q;
	logic [rpn_pkg::STATUS_W-1:0] status_q;
	logic [rpn_pkg::DEPTH_OUT_W-1:0] depth_q;

	logic                       accept;
	logic                       fin_go;
	logic                       few;
	logic [rpn_pkg::DATA_W-1:0] fin_value;
	rpn_pkg::status_t           fin_status;
	logic [rpn_pkg::SP_W-1:0]   fin_sp;
	logic                       mem_we;
	logic [rpn_pkg::IDX_W-1:0]  mem_waddr;
	logic [rpn_pkg::PROD_W-1:0] prod;
	logic [rpn_pkg::DATA_W:0]   packed_r;

	// {saturated, two's complement word} from sign and magnitude
	function automatic logic [rpn_pkg::DATA_W:0] pack(input logic neg,
			input logic [rpn_pkg::PROD_W-1:0] mag);
		logic [rpn_pkg::PROD_W-1:0] limit;
		logic [rpn_pkg::DATA_W-1:0] m;
		logic sat;
		limit = neg ? rpn_pkg::NEG_LIMIT : rpn_pkg::POS_LIMIT;
		sat = mag > limit;
		m = sat ? limit[rpn_pkg::DATA_W-1:0] : mag[rpn_pkg::DATA_W-1:0];
		return {sat, neg ? (~m + rpn_pkg::DATA_W'(1)) : m};
	endfunction

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == rpn_pkg::S_IDLE);
	assign fin_go = (state_q == rpn_pkg::S_FIN) && (!out_valid_q || out_ready);

	assign sp_m1 = sp_q - rpn_pkg::SP_W'(1);
	assign sp_m2 = sp_q - rpn_pkg::SP_W'(2);
	assign ra = sp_m1[rpn_pkg::IDX_W-1:0];
	assign rb = sp_m2[rpn_pkg::IDX_W-1:0];
	assign few = sp_q < rpn_pkg::SP_W'(2);

	assign ma_c = rd_a_q[rpn_pkg::DATA_W-1] ? (~rd_a_q + rpn_pkg::DATA_W'(1)) : rd_a_q;
	assign mb_c = rd_b_q[rpn_pkg::DATA_W-1] ? (~rd_b_q + rpn_pkg::DATA_W'(1)) : rd_b_q;

	// shared adder: sum/difference, multiply accumulate, or divide trial subtract
	always_comb begin
		case (op_q)
			rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
				alu_x = rpn_pkg::ALU_W'(signed'(rd_b_q));
				alu_y = rpn_pkg::ALU_W'(signed'(rd_a_q));
				alu_sub = (op_q == rpn_pkg::OP_SUB);
			end
			rpn_pkg::OP_MUL: begin
				alu_x = {1'b0, acc_q};
				alu_y = work_q[0] ? {2'b00, mb_q} : '0;
				alu_sub = 1'b0;
			end
			default: begin
				alu_x = {1'b0, acc_q[rpn_pkg::DATA_W-1:0], work_q[rpn_pkg::DIV_W-1]};
				alu_y = {2'b00, ma_q};
				alu_sub = 1'b1;
			end
		endcase
		alu_sum = alu_x + (alu_sub ? ~alu_y : alu_y) + rpn_pkg::ALU_W'(alu_sub);
	end

	always_comb begin
		mul_work = work_q >> 1;
		mul_work[rpn_pkg::DATA_W-1] = alu_sum[0];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpn_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rpn_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (operation == rpn_pkg::OP_PUSH) ? rpn_pkg::S_FIN : rpn_pkg::S_LOAD;
				end
			end
			rpn_pkg::S_LOAD: begin
				if (op_q > rpn_pkg::OP_REM || few) begin
					state_d = rpn_pkg::S_FIN;
				end else if ((op_q == rpn_pkg::OP_DIV || op_q == rpn_pkg::OP_REM)
						&& rd_a_q == '0) begin
					state_d = rpn_pkg::S_FIN;
				end else begin
					state_d = rpn_pkg::S_CALC;
				end
			end
			rpn_pkg::S_CALC: begin
				if (cnt_q == '0) begin
					state_d = rpn_pkg::S_FIN;
				end
			end
			rpn_pkg::S_FIN: begin
				if (fin_go) begin
					state_d = rpn_pkg::S_IDLE;
				end
			end
			default: state_d = rpn_pkg::S_IDLE;
		endcase
	end

	// result of the item, evaluated in the finishing state
	assign prod = {acc_q[rpn_pkg::DATA_W-1:0], work_q[rpn_pkg::DATA_W-1:0]};

	always_comb begin
		fin_value = '0;
		fin_status = rpn_pkg::ST_OK;
		fin_sp = sp_q;
		mem_we = 1'b0;
		mem_waddr = rb;
		packed_r = '0;
		case (op_q)
			rpn_pkg::OP_PUSH: begin
				if (sp_q == rpn_pkg::SP_W'(rpn_pkg::STACK_DEPTH)) begin
					fin_status = rpn_pkg::ST_FULL;
				end else begin
					fin_value = push_q;
					fin_sp = sp_q + rpn_pkg::SP_W'(1);
					mem_we = 1'b1;
					mem_waddr = sp_q[rpn_pkg::IDX_W-1:0];
				end
			end
			rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL,
			rpn_pkg::OP_DIV, rpn_pkg::OP_REM: begin
				if (few) begin
					fin_status = rpn_pkg::ST_FEW;
				end else begin
					fin_sp = sp_m1;
					mem_we = 1'b1;
					if (op_q == rpn_pkg::OP_ADD || op_q == rpn_pkg::OP_SUB) begin
						// 33-bit exact sum; top two bits disagree on overflow
						if (!acc_q[rpn_pkg::DATA_W] && acc_q[rpn_pkg::DATA_W-1]) begin
							fin_value = rpn_pkg::MAX_VAL;
							fin_status = rpn_pkg::ST_SAT;
						end else if (acc_q[rpn_pkg::DATA_W] && !acc_q[rpn_pkg::DATA_W-1]) begin
							fin_value = rpn_pkg::MIN_VAL;
							fin_status = rpn_pkg::ST_SAT;
						end else begin
							fin_value = acc_q[rpn_pkg::DATA_W-1:0];
						end
					end else if (op_q == rpn_pkg::OP_MUL) begin
						packed_r = pack(rd_a_q[rpn_pkg::DATA_W-1] ^ rd_b_q[rpn_pkg::DATA_W-1],
							prod >> rpn_pkg::FRAC_BITS);
						fin_value = packed_r[rpn_pkg::DATA_W-1:0];
						if (packed_r[rpn_pkg::DATA_W]) begin
							fin_status = rpn_pkg::ST_SAT;
						end
					end else if (ma_q == '0) begin
						fin_status = rpn_pkg::ST_DIV0;
						if (op_q == rpn_pkg::OP_DIV && rd_b_q != '0) begin
							fin_value = rd_b_q[rpn_pkg::DATA_W-1] ? rpn_pkg::MIN_VAL
								: rpn_pkg::MAX_VAL;
						end
					end else begin
						if (op_q == rpn_pkg::OP_DIV) begin
							packed_r = pack(rd_a_q[rpn_pkg::DATA_W-1] ^ rd_b_q[rpn_pkg::DATA_W-1],
								rpn_pkg::PROD_W'(work_q));
						end else begin
							packed_r = pack(rd_b_q[rpn_pkg::DATA_W-1], rpn_pkg::PROD_W'(acc_q));
						end
						fin_value = packed_r[rpn_pkg::DATA_W-1:0];
						if (packed_r[rpn_pkg::DATA_W]) begin
							fin_status = rpn_pkg::ST_SAT;
						end
					end
				end
			end
			default: begin
				// unused codes: report top of stack, change nothing
				if (sp_q != '0) begin
					fin_value = rd_a_q;
				end
			end
		endcase
	end

	// operand stack; reads track the top two entries every cycle
	always_ff @(posedge clk) begin
		if (fin_go && mem_we) begin
			mem[mem_waddr] <= fin_value;
		end
		rd_a_q <= mem[ra];
		rd_b_q <= mem[rb];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (fin_go) begin
				sp_q <= fin_sp;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == rpn_pkg::S_LOAD) begin
				case (op_q)
					rpn_pkg::OP_MUL: cnt_q <= rpn_pkg::CNT_W'(rpn_pkg::DATA_W - 1);
					rpn_pkg::OP_DIV, rpn_pkg::OP_REM: cnt_q <= rpn_pkg::CNT_W'(rpn_pkg::DIV_W - 1);
					default: cnt_q <= '0;
				endcase
			end else if (state_q == rpn_pkg::S_CALC) begin
				cnt_q <= cnt_q - rpn_pkg::CNT_W'(1);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operation;
			push_q <= push_value;
		end
		if (state_q == rpn_pkg::S_LOAD) begin
			ma_q <= ma_c;
			mb_q <= mb_c;
			acc_q <= '0;
			case (op_q)
				rpn_pkg::OP_MUL: work_q <= rpn_pkg::DIV_W'(ma_c);
				rpn_pkg::OP_DIV: work_q <= rpn_pkg::DIV_W'(mb_c) << rpn_pkg::FRAC_BITS;
				default: work_q <= rpn_pkg::DIV_W'(mb_c);
			endcase
		end else if (state_q == rpn_pkg::S_CALC) begin
			case (op_q)
				rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
					acc_q <= alu_sum[rpn_pkg::DATA_W:0];
				end
				rpn_pkg::OP_MUL: begin
					acc_q <= {1'b0, alu_sum[rpn_pkg::DATA_W:1]};
					work_q <= mul_work;
				end
				default: begin
					if (!alu_sum[rpn_pkg::ALU_W-1]) begin
						acc_q <= alu_sum[rpn_pkg::DATA_W:0];
					end else begin
						acc_q <= {acc_q[rpn_pkg::DATA_W-1:0], work_q[rpn_pkg::DIV_W-1]};
					end
					work_q <= {work_q[rpn_pkg::DIV_W-2:0], ~alu_sum[rpn_pkg::ALU_W-1]};
				end
			endcase
		end
		if (fin_go) begin
			res_q <= fin_value;
			status_q <= fin_status;
			depth_q <= rpn_pkg::DEPTH_OUT_W'(fin_sp);
		end
	end

	assign out_valid = out_valid_q;
	assign result_value = res_q;
	assign status = status_q;
	assign stack_depth = depth_q;

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= rpn_pkg::SP_W'(rpn_pkg::STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second transaction taken while busy");

	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == rpn_pkg::ST_FEW) |-> (result_value == '0 && stack_depth < 5'd2))
		else $error("too-few-operands result not cleared");

	a_full_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == rpn_pkg::ST_FULL)
		|-> stack_depth == rpn_pkg::DEPTH_OUT_W'(rpn_pkg::STACK_DEPTH))
		else $error("stack-full result with wrong depth");

endmodule
